/* sv/occurrence_checkpoint_interleaver_top_defines.svh */
// Assertion macros for the occurrence checkpoint interleaver checker.
// Used by the checker file only; needs clk and rst in scope.
`ifndef OCCURRENCE_CHECKPOINT_INTERLEAVER_TOP_DEFINES_SVH
`define OCCURRENCE_CHECKPOINT_INTERLEAVER_TOP_DEFINES_SVH

// same-cycle implication
`define OCI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("occurrence checkpoint interleaver check failed");

// next-cycle implication
`define OCI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("occurrence checkpoint interleaver check failed");

`endif

/* sv/oci_pkg.sv */
// Package for the occurrence checkpoint interleaver: beat types, sizes, states.
// No dependencies.
package oci_pkg;

  localparam int CHECKPOINT_INTERVAL = 128;
  localparam int SYMS_PER_WORD = 16;
  localparam int WORDS_RAW = CHECKPOINT_INTERVAL / SYMS_PER_WORD;
  localparam int WORDS_PER_CP = (WORDS_RAW < 1) ? 1 : WORDS_RAW;
  localparam int PHASE_W = (WORDS_PER_CP > 1) ? $clog2(WORDS_PER_CP) : 1;
  localparam int NUM_SYMS = 4;
  localparam int INC_W = 5;

  typedef struct packed {
    logic [31:0] bwt_word;
    logic [4:0]  valid_symbols;
    logic        last_word;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        is_count;
    logic        last_out;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_HEAD,
    ST_WORD,
    ST_TAIL
  } emit_state_t;

endpackage

/* sv/occurrence_checkpoint_interleaver_top.sv */
// Occurrence checkpoint interleaver top level: input register, beat sequencer,
// running counts and output register. Depends on oci_pkg.
//
// Each accepted word yields one beat per cycle through a single output
// register, unless result_ready holds it off: four count beats first when the
// word opens a checkpoint interval, then the word, then four final count beats
// when the word is flagged last, so a word yields 1, 5, 5 or 9 beats. The next
// word is taken in the cycle the current word's final beat leaves the
// sequencer.
module occurrence_checkpoint_interleaver_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              data_valid,
  output logic              data_ready,
  input  oci_pkg::in_beat_t data,
  output logic              result_valid,
  input  logic              result_ready,
  output oci_pkg::out_beat_t result
);
  import oci_pkg::*;

  logic                    item_valid;
  in_beat_t                item;
  logic [INC_W-1:0]        inc      [NUM_SYMS];
  logic [INC_W-1:0]        inc_next [NUM_SYMS];
  logic [SYMS_PER_WORD-1:0] hit     [NUM_SYMS];
  emit_state_t             state, state_next;
  logic [1:0]              idx, idx_next;
  logic [31:0]             counts   [NUM_SYMS];
  logic [PHASE_W-1:0]      phase;
  out_beat_t               beat;
  logic                    load_out, fire, done, do_word, do_clear;
  logic [INC_W-1:0]        nsat;

  // per-symbol counts of the incoming word
  always_comb begin
    nsat = (data.valid_symbols > INC_W'(SYMS_PER_WORD)) ? INC_W'(SYMS_PER_WORD)
                                                       : data.valid_symbols;
    for (int j = 0; j < NUM_SYMS; j++) begin
      for (int s = 0; s < SYMS_PER_WORD; s++) begin
        hit[j][s] = (INC_W'(s) < nsat) && (data.bwt_word[31-2*s -: 2] == 2'(j));
      end
      inc_next[j] = INC_W'($countones(hit[j]));
    end
  end

  assign load_out = !result_valid || result_ready;
  assign fire     = item_valid && load_out;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    done       = 1'b0;
    do_word    = 1'b0;
    do_clear   = 1'b0;
    beat       = '0;
    unique case (state)
      ST_HEAD, ST_WORD: begin
        if (state == ST_HEAD && phase == '0) begin
          beat.out_word = counts[idx];
          beat.is_count = 1'b1;
          idx_next      = idx + 2'd1;
          if (idx == 2'd3) begin
            state_next = ST_WORD;
          end
        end else begin
          beat.out_word = item.bwt_word;
          do_word       = 1'b1;
          idx_next      = '0;
          if (item.last_word) begin
            state_next = ST_TAIL;
          end else begin
            done = 1'b1;
          end
        end
      end
      ST_TAIL: begin
        beat.out_word = counts[idx];
        beat.is_count = 1'b1;
        beat.last_out = (idx == 2'd3);
        idx_next      = idx + 2'd1;
        if (idx == 2'd3) begin
          done     = 1'b1;
          do_clear = 1'b1;
        end
      end
      default: begin
        state_next = ST_HEAD;
      end
    endcase
  end

  assign data_ready = !item_valid || (fire && done);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      state      <= ST_HEAD;
      idx        <= '0;
    end else if (data_valid && data_ready) begin
      item_valid <= 1'b1;
      state      <= ST_HEAD;
      idx        <= '0;
    end else if (fire) begin
      item_valid <= !done;
      state      <= state_next;
      idx        <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) begin
      item <= data;
      inc  <= inc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NUM_SYMS; j++) begin
        counts[j] <= '0;
      end
      phase <= '0;
    end else if (fire && do_clear) begin
      for (int j = 0; j < NUM_SYMS; j++) begin
        counts[j] <= '0;
      end
      phase <= '0;
    end else if (fire && do_word) begin
      for (int j = 0; j < NUM_SYMS; j++) begin
        counts[j] <= counts[j] + 32'(inc[j]);
      end
      phase <= (phase == PHASE_W'(WORDS_PER_CP - 1)) ? '0 : phase + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= beat;
    end
  end

endmodule

/* sv/oci_checker.sv */
// Port-level checker for the occurrence checkpoint interleaver, and its bind.
// Depends on oci_pkg and occurrence_checkpoint_interleaver_top_defines.svh.
`include "occurrence_checkpoint_interleaver_top_defines.svh"

module oci_checker (
  input logic               clk,
  input logic               rst,
  input logic               data_valid,
  input logic               data_ready,
  input oci_pkg::in_beat_t  data,
  input logic               result_valid,
  input logic               result_ready,
  input oci_pkg::out_beat_t result
);
  import oci_pkg::*;

  `OCI_ASSERT_NOW(a_stall_hold, $past(result_valid && !result_ready) && !$past(rst), result_valid && $stable(result))
  `OCI_ASSERT_NEXT(a_reset_empty, rst, !result_valid)
  `OCI_ASSERT_NOW(a_last_is_count, result_valid && result.last_out, result.is_count)
  `OCI_ASSERT_NEXT(a_busy_after_last_in, data_valid && data_ready && data.last_word && !rst, !data_ready || rst)

endmodule

bind occurrence_checkpoint_interleaver_top oci_checker u_oci_checker (
  .clk          (clk),
  .rst          (rst),
  .data_valid   (data_valid),
  .data_ready   (data_ready),
  .data         (data),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

/* tb/occurrence_checkpoint_interleaver_top_tb.sv */
// Testbench for occurrence_checkpoint_interleaver_top: directed and random
// streams of symbol words, a running occurrence-count predictor and an
// in-order beat checker. Depends on oci_pkg and the top level only.
module occurrence_checkpoint_interleaver_top_tb;
  import oci_pkg::*;

  localparam logic KIND_COUNT   = 1'b1;
  localparam logic KIND_WORD    = 1'b0;
  localparam int   IDLE_PCT     = 36;
  localparam int   RANDOM_WORDS = 400;
  localparam int   HOLD_CYCLES  = 200;
  localparam int   STALL_LIMIT  = 2000;
  localparam int   DRAIN_CYCLES = 20;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       data_valid = 1'b0;
  logic       data_ready;
  in_beat_t   data = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  out_beat_t  result;

  in_beat_t   pending_words [$];
  out_beat_t  expected_beats [$];
  logic [31:0] occ_counts [NUM_SYMS];
  int         word_phase = 0;
  int         words_taken = 0;
  int         error_count = 0;
  int         stall_cycles = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  logic       calm;

  occurrence_checkpoint_interleaver_top dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data         (data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  // no idling on either side for a stretch of the stream
  assign calm = (words_taken >= 150) && (words_taken < 250);

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h", what, got, want);
    error_count++;
  endtask

  task automatic push_counts(input logic closing);
    out_beat_t b;
    for (int j = 0; j < NUM_SYMS; j++) begin
      b.out_word = occ_counts[j];
      b.is_count = KIND_COUNT;
      b.last_out = closing && (j == NUM_SYMS - 1);
      expected_beats.push_back(b);
    end
  endtask

  task automatic predict_beats(input in_beat_t w);
    out_beat_t b;
    int n;
    logic [1:0] sym;
    n = (w.valid_symbols > SYMS_PER_WORD) ? SYMS_PER_WORD : int'(w.valid_symbols);
    if (word_phase == 0) push_counts(1'b0);
    b.out_word = w.bwt_word;
    b.is_count = KIND_WORD;
    b.last_out = 1'b0;
    expected_beats.push_back(b);
    for (int s = 0; s < n; s++) begin
      sym = w.bwt_word[(SYMS_PER_WORD - 1 - s) * 2 +: 2];
      occ_counts[sym] = occ_counts[sym] + 32'd1;
    end
    word_phase = (word_phase + 1 >= WORDS_PER_CP) ? 0 : word_phase + 1;
    if (w.last_word) begin
      push_counts(1'b1);
      for (int j = 0; j < NUM_SYMS; j++) occ_counts[j] = '0;
      word_phase = 0;
    end
  endtask

  task automatic add_word(input logic [31:0] w, input logic [4:0] n, input logic lst);
    in_beat_t b;
    b.bwt_word = w;
    b.valid_symbols = n;
    b.last_word = lst;
    pending_words.push_back(b);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
    end else begin
      if (data_valid && data_ready) begin
        predict_beats(data);
        words_taken <= words_taken + 1;
      end
      if (!data_valid || data_ready) begin
        if (pending_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          data <= pending_words.pop_front();
          data_valid <= 1'b1;
        end else begin
          data_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat", result.out_word, '0);
        end else begin
          out_beat_t want;
          want = expected_beats.pop_front();
          if (result.out_word !== want.out_word)
            report_mismatch("out_word", result.out_word, want.out_word);
          if (result.is_count !== want.is_count)
            report_mismatch("is_count", 32'(result.is_count), 32'(want.is_count));
          if (result.last_out !== want.last_out)
            report_mismatch("last_out", 32'(result.last_out), 32'(want.last_out));
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        result_ready <= 1'b0;
      end else if (!hold_done && words_taken >= 300) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        result_ready <= 1'b0;
      end else begin
        result_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((data_valid && data_ready) || (result_valid && result_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int len;
    int target;
    logic lst;
    logic [4:0] n;

    for (int j = 0; j < NUM_SYMS; j++) occ_counts[j] = '0;

    // directed: pure symbols, zero, saturating and short counts, lone last word
    add_word(32'h0000_0000, 5'd16, 1'b0);
    add_word(32'h5555_5555, 5'd16, 1'b0);
    add_word(32'hAAAA_AAAA, 5'd16, 1'b0);
    add_word(32'hFFFF_FFFF, 5'd16, 1'b0);
    add_word(32'h1B1B_1B1B, 5'd0,  1'b0);
    add_word(32'hE4E4_E4E4, 5'd31, 1'b0);
    add_word(32'h1234_5678, 5'd17, 1'b0);
    add_word(32'h9ABC_DEF0, 5'd5,  1'b0);
    add_word(32'hDEAD_BEEF, 5'd16, 1'b0);
    add_word(32'hCAFE_F00D, 5'd7,  1'b1);
    add_word(32'hFFFF_FFFF, 5'd16, 1'b1);
    add_word(32'h0F0F_0F0F, 5'd0,  1'b1);
    add_word(32'h8000_0001, 5'd1,  1'b0);
    add_word(32'h7FFF_FFFE, 5'd15, 1'b0);
    add_word(32'hC3C3_C3C3, 5'd31, 1'b1);
    add_word(32'h3C3C_3C3C, 5'd16, 1'b1);

    target = pending_words.size() + RANDOM_WORDS;
    while (pending_words.size() < target) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 17) : $urandom_range(16, 1);
      for (int i = 0; i < len; i++) begin
        lst = (i == len - 1) && ($urandom_range(19) != 0);
        if (lst)
          n = ($urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 1));
        else
          n = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'd16;
        add_word($urandom, n, lst);
      end
    end
    add_word($urandom, 5'($urandom_range(16, 1)), 1'b1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || data_valid) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
